[hdl/stereo_pose_blend_macros.svh]
// Assertion helpers shared by the checking code of the pose blender.
`ifndef STEREO_POSE_BLEND_MACROS_SVH
`define STEREO_POSE_BLEND_MACROS_SVH

// cond holds at every clock edge out of reset
`define SPB_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// cons holds in the same cycle as ante
`define SPB_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// cons holds in the cycle after ante
`define SPB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/spb_pkg.sv]
package spb_pkg;

    localparam int POS_W      = 32;
    localparam int Q_W        = 16;
    localparam int S_W        = Q_W + 1;          // q1 +/- q2
    localparam int PROD_W     = 2 * S_W;
    localparam int DOT_W      = PROD_W + 2;
    localparam int N_W        = PROD_W + 1;       // sum of four squares
    localparam int NORM_SHIFT = 28;
    localparam int OP_W       = 64;               // N << 28, padded
    localparam int ROOT_W     = OP_W / 2;
    localparam int REM_W      = ROOT_W + 2;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = S_W;              // quotient bits
    localparam int NUM_SHIFT  = 30;
    localparam int NUM_W      = 48;
    localparam int DREM_W     = ROOT_W + 1;       // divisor is 2 * root
    localparam int CNT_W      = 5;

    localparam logic signed [Q_W-1:0] Q_ONE     = 16'sh7FFF;
    localparam logic [S_W-1:0]        Q_MAG_POS = 17'd32767;
    localparam logic [S_W-1:0]        Q_MAG_NEG = 17'd32768;

    typedef struct packed {
        logic load_first;
        logic capture;
        logic dot_mul;
        logic dot_sum;
        logic sq_mul;
        logic sq_sum;
        logic sqrt_init;
        logic sqrt_step;
        logic div_init;
        logic div_step;
        logic wb;
        logic ident;
        logic out_load;
        logic out_blended;
        logic out_degen;
    } cmd_t;

    typedef struct packed {
        logic n_zero;
    } sts_t;

endpackage

[hdl/stereo_pose_blend.sv]
// Channel   Direction  Handshake            Payload
// in        sink       in_valid / in_stall  pos_x..pos_z, quat_x..quat_w, last_view
// out       source     out_valid/out_stall  head_x..head_z, head_qx..head_qw,
//                                           was_blended, degenerate
//
// First view: loaded into the held pose. Second view: 4 multiply/sum steps, norm
// check, 32-step square root, divider load, 17 divide steps, write back.
// A zero-norm second view ends at the norm check and holds the identity orientation.
// The view that closes a frame then passes through S_EMIT to load the output register.
// Reset clears the frame state and the output valid; held poses are not reset.
// A stalled output transaction holds; in_stall stays high until it is taken.
`include "stereo_pose_blend_macros.svh"

module stereo_pose_blend
    import spb_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [POS_W-1:0] pos_x,
    input  logic signed [POS_W-1:0] pos_y,
    input  logic signed [POS_W-1:0] pos_z,
    input  logic signed [Q_W-1:0]   quat_x,
    input  logic signed [Q_W-1:0]   quat_y,
    input  logic signed [Q_W-1:0]   quat_z,
    input  logic signed [Q_W-1:0]   quat_w,
    input  logic                    last_view,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [POS_W-1:0] head_x,
    output logic signed [POS_W-1:0] head_y,
    output logic signed [POS_W-1:0] head_z,
    output logic signed [Q_W-1:0]   head_qx,
    output logic signed [Q_W-1:0]   head_qy,
    output logic signed [Q_W-1:0]   head_qz,
    output logic signed [Q_W-1:0]   head_qw,
    output logic                    was_blended,
    output logic                    degenerate
);

    cmd_t        cmd;
    sts_t        sts;
    logic        q_is_ident;
    logic [12:0] cmd_bits;

    spb_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_view (last_view),
        .out_stall (out_stall),
        .sts       (sts),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    spb_datapath u_dp
    (
        .clk         (clk),
        .cmd         (cmd),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .quat_x      (quat_x),
        .quat_y      (quat_y),
        .quat_z      (quat_z),
        .quat_w      (quat_w),
        .sts         (sts),
        .head_x      (head_x),
        .head_y      (head_y),
        .head_z      (head_z),
        .head_qx     (head_qx),
        .head_qy     (head_qy),
        .head_qz     (head_qz),
        .head_qw     (head_qw),
        .was_blended (was_blended),
        .degenerate  (degenerate)
    );

    assign q_is_ident = (head_qx == '0) && (head_qy == '0) && (head_qz == '0)
                     && (head_qw == Q_ONE);
    assign cmd_bits   = {cmd.load_first, cmd.capture, cmd.dot_mul, cmd.dot_sum,
                         cmd.sq_mul, cmd.sq_sum, cmd.sqrt_init, cmd.sqrt_step,
                         cmd.div_init, cmd.div_step, cmd.wb, cmd.ident, cmd.out_load};

    `SPB_ASSERT_IMPLIES(a_degen_blended, out_valid && degenerate, was_blended, "degen unblended")
    `SPB_ASSERT_IMPLIES(a_degen_identity, out_valid && degenerate, q_is_ident, "degen not ident")
    `SPB_ASSERT_NEXT(a_load_shows, cmd.out_load, out_valid, "loaded result not presented")
    `SPB_ASSERT_ALWAYS(a_one_cmd, $onehot0(cmd_bits), "datapath commands overlap")

endmodule

[hdl/spb_datapath.sv]
module spb_datapath
    import spb_pkg::*;
(
    input  logic                    clk,
    input  cmd_t                    cmd,
    input  logic signed [POS_W-1:0] pos_x,
    input  logic signed [POS_W-1:0] pos_y,
    input  logic signed [POS_W-1:0] pos_z,
    input  logic signed [Q_W-1:0]   quat_x,
    input  logic signed [Q_W-1:0]   quat_y,
    input  logic signed [Q_W-1:0]   quat_z,
    input  logic signed [Q_W-1:0]   quat_w,
    output sts_t                    sts,
    output logic signed [POS_W-1:0] head_x,
    output logic signed [POS_W-1:0] head_y,
    output logic signed [POS_W-1:0] head_z,
    output logic signed [Q_W-1:0]   head_qx,
    output logic signed [Q_W-1:0]   head_qy,
    output logic signed [Q_W-1:0]   head_qz,
    output logic signed [Q_W-1:0]   head_qw,
    output logic                    was_blended,
    output logic                    degenerate
);

    logic signed [POS_W-1:0]  in_pos [3];
    logic signed [Q_W-1:0]    in_q   [4];

    logic signed [POS_W-1:0]  hp_reg   [3];
    logic signed [Q_W-1:0]    hq_reg   [4];
    logic signed [Q_W-1:0]    q2_reg   [4];
    logic signed [PROD_W-1:0] prod_reg [4];
    logic signed [S_W-1:0]    s_reg    [4];
    logic [N_W-1:0]           n_reg;
    logic [OP_W-1:0]          op_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [ROOT_W-1:0]        root_reg;
    logic [DREM_W-1:0]        drem_reg [4];
    logic [S_W-1:0]           dq_reg   [4];

    logic signed [POS_W-1:0]  out_pos_reg [3];
    logic signed [Q_W-1:0]    out_q_reg   [4];
    logic                     out_blended_reg;
    logic                     out_degen_reg;

    logic signed [POS_W:0]    pos_sum  [3];
    logic signed [S_W-1:0]    mul_a    [4];
    logic signed [S_W-1:0]    mul_b    [4];
    logic signed [DOT_W-1:0]  dot;
    logic signed [S_W-1:0]    s_next   [4];
    logic [N_W-1:0]           n_next;
    logic [REM_W+1:0]         rem_sh;
    logic [REM_W+1:0]         trial;
    logic                     sq_ge;
    logic [DREM_W:0]          div_d;
    logic [DREM_W:0]          div_t    [4];
    logic                     div_ge   [4];
    logic signed [S_W:0]      s_wide   [4];
    logic [S_W:0]             s_mag    [4];
    logic [NUM_W-1:0]         num      [4];
    logic [S_W-1:0]           q_sat    [4];
    logic signed [Q_W-1:0]    q_fin    [4];

    assign in_pos[0] = pos_x;
    assign in_pos[1] = pos_y;
    assign in_pos[2] = pos_z;
    assign in_q[0]   = quat_x;
    assign in_q[1]   = quat_y;
    assign in_q[2]   = quat_z;
    assign in_q[3]   = quat_w;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pos_sum[i] = (POS_W+1)'(hp_reg[i]) + (POS_W+1)'(in_pos[i]);
        end
        for (int i = 0; i < 4; i++)
        begin
            mul_a[i] = cmd.sq_mul ? s_reg[i] : S_W'(hq_reg[i]);
            mul_b[i] = cmd.sq_mul ? s_reg[i] : S_W'(q2_reg[i]);
        end
        dot = DOT_W'(prod_reg[0]) + DOT_W'(prod_reg[1])
            + DOT_W'(prod_reg[2]) + DOT_W'(prod_reg[3]);
        for (int i = 0; i < 4; i++)
        begin
            // align the second view with the first before adding
            s_next[i] = dot[DOT_W-1] ? S_W'(hq_reg[i]) - S_W'(q2_reg[i])
                                     : S_W'(hq_reg[i]) + S_W'(q2_reg[i]);
        end
        n_next = N_W'($unsigned(prod_reg[0])) + N_W'($unsigned(prod_reg[1]))
               + N_W'($unsigned(prod_reg[2])) + N_W'($unsigned(prod_reg[3]));
    end

    // restoring square root, one root bit per step
    always_comb
    begin
        rem_sh = {rem_reg, op_reg[OP_W-1:OP_W-2]};
        trial  = {2'b00, root_reg, 2'b01};
        sq_ge  = rem_sh >= trial;
    end

    // four restoring dividers against 2 * root
    always_comb
    begin
        div_d = {1'b0, root_reg, 1'b0};
        for (int i = 0; i < 4; i++)
        begin
            div_t[i]  = {drem_reg[i], dq_reg[i][S_W-1]};
            div_ge[i] = div_t[i] >= div_d;
            s_wide[i] = (S_W+1)'(s_reg[i]);
            s_mag[i]  = s_reg[i][S_W-1] ? $unsigned(-s_wide[i]) : $unsigned(s_wide[i]);
            num[i]    = (NUM_W'(s_mag[i][S_W-1:0]) << NUM_SHIFT) + NUM_W'(root_reg);
            if (s_reg[i][S_W-1])
            begin
                q_sat[i] = (dq_reg[i] > Q_MAG_NEG) ? Q_MAG_NEG : dq_reg[i];
                q_fin[i] = Q_W'(~q_sat[i] + 1'b1);
            end
            else
            begin
                q_sat[i] = (dq_reg[i] > Q_MAG_POS) ? Q_MAG_POS : dq_reg[i];
                q_fin[i] = Q_W'(q_sat[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_first)
        begin
            hp_reg <= in_pos;
        end
        else if (cmd.capture)
        begin
            for (int i = 0; i < 3; i++)
            begin
                hp_reg[i] <= pos_sum[i][POS_W:1];
            end
        end

        if (cmd.load_first)
        begin
            hq_reg <= in_q;
        end
        else if (cmd.ident)
        begin
            hq_reg[0] <= '0;
            hq_reg[1] <= '0;
            hq_reg[2] <= '0;
            hq_reg[3] <= Q_ONE;
        end
        else if (cmd.wb)
        begin
            hq_reg <= q_fin;
        end

        if (cmd.capture)
        begin
            q2_reg <= in_q;
        end

        if (cmd.dot_mul || cmd.sq_mul)
        begin
            for (int i = 0; i < 4; i++)
            begin
                prod_reg[i] <= mul_a[i] * mul_b[i];
            end
        end

        if (cmd.dot_sum)
        begin
            s_reg <= s_next;
        end

        if (cmd.sq_sum)
        begin
            n_reg <= n_next;
        end

        if (cmd.sqrt_init)
        begin
            op_reg   <= {1'b0, n_reg, NORM_SHIFT'(0)};
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            op_reg   <= {op_reg[OP_W-3:0], 2'b00};
            rem_reg  <= sq_ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
            root_reg <= {root_reg[ROOT_W-2:0], sq_ge};
        end

        for (int i = 0; i < 4; i++)
        begin
            if (cmd.div_init)
            begin
                drem_reg[i] <= DREM_W'(num[i][NUM_W-1:DIV_STEPS]);
                dq_reg[i]   <= num[i][DIV_STEPS-1:0];
            end
            else if (cmd.div_step)
            begin
                drem_reg[i] <= div_ge[i] ? DREM_W'(div_t[i] - div_d) : div_t[i][DREM_W-1:0];
                dq_reg[i]   <= {dq_reg[i][S_W-2:0], div_ge[i]};
            end
        end

        if (cmd.out_load)
        begin
            out_pos_reg     <= hp_reg;
            out_q_reg       <= hq_reg;
            out_blended_reg <= cmd.out_blended;
            out_degen_reg   <= cmd.out_degen;
        end
    end

    assign sts.n_zero  = (n_reg == '0);

    assign head_x      = out_pos_reg[0];
    assign head_y      = out_pos_reg[1];
    assign head_z      = out_pos_reg[2];
    assign head_qx     = out_q_reg[0];
    assign head_qy     = out_q_reg[1];
    assign head_qz     = out_q_reg[2];
    assign head_qw     = out_q_reg[3];
    assign was_blended = out_blended_reg;
    assign degenerate  = out_degen_reg;

endmodule

[hdl/spb_ctrl.sv]
module spb_ctrl
    import spb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic last_view,
    input  logic out_stall,
    input  sts_t sts,
    output logic in_stall,
    output logic out_valid,
    output cmd_t cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DOT_MUL  = 4'd1;
    localparam logic [3:0] S_DOT_SUM  = 4'd2;
    localparam logic [3:0] S_SQ_MUL   = 4'd3;
    localparam logic [3:0] S_SQ_SUM   = 4'd4;
    localparam logic [3:0] S_CHECK    = 4'd5;
    localparam logic [3:0] S_SQRT     = 4'd6;
    localparam logic [3:0] S_DIV_INIT = 4'd7;
    localparam logic [3:0] S_DIV      = 4'd8;
    localparam logic [3:0] S_WB       = 4'd9;
    localparam logic [3:0] S_EMIT     = 4'd10;

    localparam logic [1:0] VS_EMPTY = 2'd0;
    localparam logic [1:0] VS_FIRST = 2'd1;
    localparam logic [1:0] VS_BLEND = 2'd2;
    localparam logic [1:0] VS_DEGEN = 2'd3;

    logic [3:0]       state_reg, state_next;
    logic [1:0]       vs_reg, vs_next;
    logic             last_reg, last_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        vs_next    = vs_reg;
        last_next  = last_reg;
        cnt_next   = cnt_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (vs_reg)
                        VS_EMPTY:
                        begin
                            cmd.load_first = 1'b1;
                            vs_next        = VS_FIRST;
                            state_next     = last_view ? S_EMIT : S_IDLE;
                        end
                        VS_FIRST:
                        begin
                            cmd.capture = 1'b1;
                            last_next   = last_view;
                            state_next  = S_DOT_MUL;
                        end
                        default:
                        begin
                            // views past the second only close the frame
                            state_next = last_view ? S_EMIT : S_IDLE;
                        end
                    endcase
                end
            end
            S_DOT_MUL:
            begin
                cmd.dot_mul = 1'b1;
                state_next  = S_DOT_SUM;
            end
            S_DOT_SUM:
            begin
                cmd.dot_sum = 1'b1;
                state_next  = S_SQ_MUL;
            end
            S_SQ_MUL:
            begin
                cmd.sq_mul = 1'b1;
                state_next = S_SQ_SUM;
            end
            S_SQ_SUM:
            begin
                cmd.sq_sum = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (sts.n_zero)
                begin
                    cmd.ident  = 1'b1;
                    vs_next    = VS_DEGEN;
                    state_next = last_reg ? S_EMIT : S_IDLE;
                end
                else
                begin
                    cmd.sqrt_init = 1'b1;
                    cnt_next      = '0;
                    state_next    = S_SQRT;
                end
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                begin
                    state_next = S_DIV_INIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_WB;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_WB:
            begin
                cmd.wb     = 1'b1;
                vs_next    = VS_BLEND;
                state_next = last_reg ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.out_load    = 1'b1;
                    cmd.out_blended = vs_reg[1];
                    cmd.out_degen   = (vs_reg == VS_DEGEN);
                    vs_next         = VS_EMPTY;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = cmd.out_load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vs_reg        <= VS_EMPTY;
            last_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vs_reg        <= vs_next;
            last_reg      <= last_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[test/stereo_pose_blend_tb.sv]
module stereo_pose_blend_tb;
    import spb_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int SETTLE       = 70;
    localparam int PHASE_VIEWS  = 450;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [Q_W-1:0]   quat_x;
        logic signed [Q_W-1:0]   quat_y;
        logic signed [Q_W-1:0]   quat_z;
        logic signed [Q_W-1:0]   quat_w;
        logic                    last_view;
    } view_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic signed [Q_W-1:0]   qx;
        logic signed [Q_W-1:0]   qy;
        logic signed [Q_W-1:0]   qz;
        logic signed [Q_W-1:0]   qw;
        logic                    blended;
        logic                    degen;
    } head_pose_t;

    typedef struct packed {
        view_t      v;
        logic       has_exp;
        head_pose_t want;
    } dir_row_t;

    typedef enum logic [1:0] {NO_VIEW, FIRST_HELD, BLEND_HELD, BLEND_DEGEN} pred_stage_e;

    localparam int DIR_ROWS = 22;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        // one-view frame straight after reset
        '{'{32'h7FFFFFFF, 32'h80000000, 32'h00000000, 16'h0001, 16'h0002, 16'h0003,
            16'h0004, 1'b1}, 1'b1,
          '{32'h7FFFFFFF, 32'h80000000, 32'h00000000, 16'h0001, 16'h0002, 16'h0003,
            16'h0004, 1'b0, 1'b0}},
        '{'{32'h80000000, 32'h80000000, 32'hFFFFFFFF, 16'h8000, 16'h8000, 16'h8000,
            16'h8000, 1'b1}, 1'b1,
          '{32'h80000000, 32'h80000000, 32'hFFFFFFFF, 16'h8000, 16'h8000, 16'h8000,
            16'h8000, 1'b0, 1'b0}},
        // zero quaternions: identity, position extremes
        '{'{32'h7FFFFFFF, 32'h80000000, 32'h80000000, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0},
          1'b0, '0},
        '{'{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 16'h0, 16'h0, 16'h0, 16'h0, 1'b1},
          1'b1,
          '{32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 16'h0, 16'h0, 16'h0, Q_ONE,
            1'b1, 1'b1}},
        // degenerate blend followed by an ignored view
        '{'{32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0}, 1'b0, '0},
        '{'{32'h2, 32'h4, 32'hFFFFFFFA, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0}, 1'b0, '0},
        '{'{32'h12345678, 32'h0BADF00D, 32'h55AA55AA, 16'h1234, 16'h4321, 16'h0F0F,
            16'h7000, 1'b1}, 1'b1,
          '{32'h1, 32'h2, 32'hFFFFFFFD, 16'h0, 16'h0, 16'h0, Q_ONE, 1'b1, 1'b1}},
        // identical identity views: rounding saturates at +1
        '{'{32'h00010000, 32'hFFFF0000, 32'h5, 16'h0, 16'h0, 16'h0, 16'h7FFF, 1'b0},
          1'b0, '0},
        '{'{32'h00030000, 32'hFFFD0000, 32'h0, 16'h0, 16'h0, 16'h0, 16'h7FFF, 1'b1},
          1'b1,
          '{32'h00020000, 32'hFFFE0000, 32'h2, 16'h0, 16'h0, 16'h0, Q_ONE, 1'b1, 1'b0}},
        // all components at -1
        '{'{32'h0, 32'h0, 32'h0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0},
          1'b0, '0},
        '{'{32'h1, 32'hFFFFFFFF, 32'h3, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1},
          1'b1,
          '{32'h0, 32'hFFFFFFFF, 32'h1, 16'hC000, 16'hC000, 16'hC000, 16'hC000,
            1'b1, 1'b0}},
        // negative dot product
        '{'{32'h00100000, 32'h00200000, 32'hFFF00000, 16'd1000, 16'd2000, 16'd3000,
            16'd30000, 1'b0}, 1'b0, '0},
        '{'{32'h00300000, 32'hFFE00000, 32'h00100000, -16'sd1100, -16'sd2100,
            -16'sd2900, -16'sd29000, 1'b1}, 1'b0, '0},
        // orthogonal, dot zero
        '{'{32'h0, 32'h0, 32'h0, 16'h7FFF, 16'h0, 16'h0, 16'h0, 1'b0}, 1'b0, '0},
        '{'{32'h0, 32'h0, 32'h0, 16'h0, 16'h7FFF, 16'h0, 16'h0, 1'b1}, 1'b0, '0},
        // max against min
        '{'{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 16'h7FFF, 16'h7FFF, 16'h7FFF,
            16'h7FFF, 1'b0}, 1'b0, '0},
        '{'{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 16'h8000, 16'h8000, 16'h8000,
            16'h8000, 1'b1}, 1'b0, '0},
        // four-view frame, last two ignored, then a one-view frame
        '{'{32'h00008000, 32'h1, 32'h2, 16'h0, 16'h0, 16'h5A82, 16'h5A82, 1'b0},
          1'b0, '0},
        '{'{32'h00018000, 32'h3, 32'h7, 16'h5A82, 16'h0, 16'h0, 16'h5A82, 1'b0},
          1'b0, '0},
        '{'{32'hDEAD0000, 32'h0000BEEF, 32'h1, 16'h8000, 16'h7FFF, 16'h0, 16'h1, 1'b0},
          1'b0, '0},
        '{'{32'h0, 32'hFFFFFFFF, 32'h7FFFFFFF, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF,
            1'b1}, 1'b0, '0},
        '{'{32'h12345678, 32'h0BADF00D, 32'hA5A5A5A5, 16'h7FFF, 16'h8000, 16'h0001,
            16'hFFFF, 1'b1}, 1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic out_valid;
    logic out_stall = 1'b0;
    view_t drv = '0;
    logic row_has_exp = 1'b0;
    head_pose_t row_exp = '0;

    logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
    logic signed [Q_W-1:0]   quat_x, quat_y, quat_z, quat_w;
    logic                    last_view;
    logic signed [POS_W-1:0] head_x, head_y, head_z;
    logic signed [Q_W-1:0]   head_qx, head_qy, head_qz, head_qw;
    logic                    was_blended, degenerate;

    assign pos_x     = drv.pos_x;
    assign pos_y     = drv.pos_y;
    assign pos_z     = drv.pos_z;
    assign quat_x    = drv.quat_x;
    assign quat_y    = drv.quat_y;
    assign quat_z    = drv.quat_z;
    assign quat_w    = drv.quat_w;
    assign last_view = drv.last_view;

    stereo_pose_blend dut (.*);

    // predictor state
    logic signed [POS_W-1:0] held_pos [3];
    logic signed [Q_W-1:0]   held_q [4];
    pred_stage_e             pred_stage = NO_VIEW;

    head_pose_t pose_q [$];
    int mismatches = 0;
    int views_taken = 0;
    int frames_seen = 0;
    int blends_seen = 0;
    int degens_seen = 0;
    int cycle_count = 0;
    int tx_pct = 0;
    int rx_pct = 0;
    int hold_cycles = 0;

    initial begin
        forever #6 clk = ~clk;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [POS_W-1:0] mid_pos(input logic signed [POS_W-1:0] a,
                                                        input logic signed [POS_W-1:0] b);
        longint sum;
        sum = longint'(a) + longint'(b);
        return POS_W'(sum >>> 1);
    endfunction

    // blends view v into the held pose, returns 1 on a zero-norm sum
    function automatic bit blend_views(input view_t v);
        longint q1 [4];
        longint q2 [4];
        longint s [4];
        longint dot;
        longint unsigned n, r, a, q;
        held_pos[0] = mid_pos(held_pos[0], v.pos_x);
        held_pos[1] = mid_pos(held_pos[1], v.pos_y);
        held_pos[2] = mid_pos(held_pos[2], v.pos_z);
        q2[0] = v.quat_x;
        q2[1] = v.quat_y;
        q2[2] = v.quat_z;
        q2[3] = v.quat_w;
        dot = 0;
        for (int i = 0; i < 4; i++)
        begin
            q1[i] = held_q[i];
            dot += q1[i] * q2[i];
        end
        n = 0;
        for (int i = 0; i < 4; i++)
        begin
            s[i] = q1[i] + ((dot < 0) ? -q2[i] : q2[i]);
            n += longint'(s[i] * s[i]);
        end
        if (n == 0)
        begin
            held_q[0] = '0;
            held_q[1] = '0;
            held_q[2] = '0;
            held_q[3] = Q_ONE;
            return 1'b1;
        end
        r = int_sqrt(n << NORM_SHIFT);
        for (int i = 0; i < 4; i++)
        begin
            a = (s[i] < 0) ? longint'(-s[i]) : longint'(s[i]);
            q = ((a << NUM_SHIFT) + r) / (2 * r);
            if (s[i] < 0)
            begin
                if (q > 32768) q = 32768;
                held_q[i] = Q_W'(64'd0 - q);
            end
            else
            begin
                if (q > 32767) q = 32767;
                held_q[i] = Q_W'(q);
            end
        end
        return 1'b0;
    endfunction

    function automatic head_pose_t held_pose(input bit blended, input bit degen);
        return '{held_pos[0], held_pos[1], held_pos[2], held_q[0], held_q[1], held_q[2],
                 held_q[3], blended, degen};
    endfunction

    function automatic bit predict_head(input view_t v, output head_pose_t h);
        bit dg;
        h = '0;
        case (pred_stage)
            NO_VIEW:
            begin
                held_pos[0] = v.pos_x;
                held_pos[1] = v.pos_y;
                held_pos[2] = v.pos_z;
                held_q[0] = v.quat_x;
                held_q[1] = v.quat_y;
                held_q[2] = v.quat_z;
                held_q[3] = v.quat_w;
                if (v.last_view)
                begin
                    h = held_pose(1'b0, 1'b0);
                    return 1'b1;
                end
                pred_stage = FIRST_HELD;
                return 1'b0;
            end
            FIRST_HELD:
            begin
                dg = blend_views(v);
                if (v.last_view)
                begin
                    h = held_pose(1'b1, dg);
                    pred_stage = NO_VIEW;
                    return 1'b1;
                end
                pred_stage = dg ? BLEND_DEGEN : BLEND_HELD;
                return 1'b0;
            end
            default:
            begin
                if (v.last_view)
                begin
                    h = held_pose(1'b1, pred_stage == BLEND_DEGEN);
                    pred_stage = NO_VIEW;
                    return 1'b1;
                end
                return 1'b0;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH frame %0d: %s", frames_seen, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // transaction monitor and scoreboard
    always @(posedge clk)
    begin
        head_pose_t got, want, pred;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = '{head_x, head_y, head_z, head_qx, head_qy, head_qz, head_qw,
                        was_blended, degenerate};
                if (pose_q.size() == 0)
                begin
                    report_mismatch("result with nothing pending");
                end
                else
                begin
                    want = pose_q.pop_front();
                    check_field("head_x", got.x, want.x);
                    check_field("head_y", got.y, want.y);
                    check_field("head_z", got.z, want.z);
                    check_field("head_qx", got.qx, want.qx);
                    check_field("head_qy", got.qy, want.qy);
                    check_field("head_qz", got.qz, want.qz);
                    check_field("head_qw", got.qw, want.qw);
                    check_field("was_blended", got.blended, want.blended);
                    check_field("degenerate", got.degen, want.degen);
                    blends_seen += want.blended;
                    degens_seen += want.degen;
                end
                frames_seen++;
            end
            if (in_valid && !in_stall)
            begin
                views_taken++;
                if (predict_head(drv, pred))
                    pose_q = {pose_q, row_has_exp ? row_exp : pred};
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     pose_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver
    initial begin
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                hold_cycles--;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < rx_pct);
            end
        end
    end

    task automatic send_view(input view_t v, input bit has_exp, input head_pose_t want);
        if (tx_pct != 0 && $urandom_range(0, 99) < tx_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < tx_pct);
        end
        drv <= v;
        row_has_exp <= has_exp;
        row_exp <= want;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    function automatic logic [31:0] pick_word(input int w);
        case ($urandom_range(0, 3))
            0: return 32'(1) << (w - 1);
            1: return (32'(1) << (w - 1)) - 1;
            2: return '0;
            default: return '1;
        endcase
    endfunction

    function automatic view_t rand_view();
        view_t v;
        v.pos_x = $urandom();
        v.pos_y = $urandom();
        v.pos_z = $urandom();
        v.quat_x = Q_W'($urandom_range(0, 65535));
        v.quat_y = Q_W'($urandom_range(0, 65535));
        v.quat_z = Q_W'($urandom_range(0, 65535));
        v.quat_w = Q_W'($urandom_range(0, 65535));
        if ($urandom_range(0, 9) == 0)
        begin
            v.pos_x = pick_word(POS_W);
            v.pos_z = pick_word(POS_W);
            v.quat_y = Q_W'(pick_word(Q_W));
            v.quat_w = Q_W'(pick_word(Q_W));
        end
        v.last_view = 1'b0;
        return v;
    endfunction

    function automatic logic signed [Q_W-1:0] jitter(input logic signed [Q_W-1:0] q,
                                                     input bit flip);
        logic signed [Q_W-1:0] d;
        d = Q_W'($urandom_range(0, 64)) - 16'sd32;
        return (flip ? -q : q) + d;
    endfunction

    task automatic send_frame(output int sent);
        view_t first, v;
        int nviews, kind;
        head_pose_t none;
        none = '0;
        kind = $urandom_range(0, 99);
        nviews = (kind < 25) ? 1 : (kind < 75) ? 2 : $urandom_range(3, 6);
        first = rand_view();
        kind = $urandom_range(0, 19);
        if (kind == 0 && nviews > 1)
        begin
            first.quat_x = '0;
            first.quat_y = '0;
            first.quat_z = '0;
            first.quat_w = '0;
        end
        for (int i = 0; i < nviews; i++)
        begin
            v = rand_view();
            if (i == 0)
            begin
                v = first;
            end
            else if (i == 1)
            begin
                if (kind == 0)
                begin
                    v.quat_x = '0;
                    v.quat_y = '0;
                    v.quat_z = '0;
                    v.quat_w = '0;
                end
                else if (kind < 12)
                begin
                    v.quat_x = jitter(first.quat_x, kind[0]);
                    v.quat_y = jitter(first.quat_y, kind[0]);
                    v.quat_z = jitter(first.quat_z, kind[0]);
                    v.quat_w = jitter(first.quat_w, kind[0]);
                end
            end
            v.last_view = (i == nviews - 1);
            send_view(v, 1'b0, none);
        end
        sent = nviews;
    endtask

    initial begin
        int phase_views, n;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_view(DIR_TABLE[i].v, DIR_TABLE[i].has_exp, DIR_TABLE[i].want);

        for (int phase = 0; phase < 4; phase++)
        begin
            in_valid <= 1'b0;
            while (pose_q.size() != 0) @(posedge clk);
            repeat (SETTLE) @(posedge clk);
            case (phase)
                0: begin tx_pct = 0;  rx_pct = 0;  hold_cycles = HOLD_CYCLES; end
                1: begin tx_pct = 58; rx_pct = 0;  end
                2: begin tx_pct = 0;  rx_pct = 58; end
                default: begin tx_pct = 37; rx_pct = 37; end
            endcase
            phase_views = 0;
            while (phase_views < PHASE_VIEWS)
            begin
                send_frame(n);
                phase_views += n;
            end
        end
        in_valid <= 1'b0;

        n = 0;
        while (pose_q.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        repeat (SETTLE) @(posedge clk);
        if (pose_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pose_q.size()));

        $display("%0d views taken, %0d frame results checked", views_taken, frames_seen);
        $display("%0d blended, %0d zero-norm, %0d mismatches", blends_seen, degens_seen,
                 mismatches);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/spb_pkg.sv
hdl/spb_datapath.sv
hdl/spb_ctrl.sv
hdl/stereo_pose_blend.sv
test/stereo_pose_blend_tb.sv
